// ===== rtl/lbps_pkg.sv =====
package lbps_pkg;

	localparam int unsigned MODE_W = 3;
	localparam int unsigned STEP_W = 3;
	localparam int unsigned CNT_W  = 6;	// longest duration is 55 ticks

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_SET  = 2'd1,
		ACT_NEXT = 2'd2
	} action_t;

	localparam logic [MODE_W-1:0] MODE_OFF         = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ON          = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FIRST_FLASH = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LAST        = 3'd4;

	// Per-step durations of the flash patterns; a zero ends the pattern.
	function automatic logic [CNT_W-1:0] pattern_dur(
		input logic [MODE_W-1:0] mode,
		input logic [STEP_W-1:0] step
	);
		logic [CNT_W-1:0] dur;
		dur = '0;
		case (step)
			3'd0: dur = 6'd55;
			3'd1: dur = 6'd8;
			3'd2, 3'd4: dur = (mode == 3'd3 || mode == 3'd4) ? 6'd15 : 6'd0;
			3'd3: dur = (mode == 3'd3 || mode == 3'd4) ? 6'd8 : 6'd0;
			3'd5: dur = (mode == 3'd4) ? 6'd8 : 6'd0;
			default: dur = '0;
		endcase
		if (step == 3'd4 && mode != 3'd4) begin
			dur = '0;
		end
		return dur;
	endfunction

endpackage

// ===== rtl/led_blink_pattern_sequencer.sv =====
// LED blink pattern sequencer.
//
// Input channel s_axis_*: one item per handshake. tuser carries the action
// (tick, set mode, step to next mode), tdata carries the mode for a set.
// Output channel m_axis_*: exactly one result item per input item, holding
// the LED level and the current mode after that item.
//
// The result of an accepted item is registered and shown on m_axis from
// the next cycle. Throughput is one item per clock unless the receiver
// stalls a full result register; mode, step, countdown and LED registers
// update together per accepted item, with a result register in between.
//
// While the receiver stalls, the result register holds and s_axis_tready
// stays high only if the result register is empty or is being taken in the
// same cycle, so no result is lost.
//
// Reset (arst_n low) puts the LED off, mode off, step and countdown at zero,
// and empties the result register.
module led_blink_pattern_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,	// [2:0] mode, [7:3] zero
	input  logic [1:0] s_axis_tuser,	// [1:0] action
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata	// [0] led_on, [3:1] mode_now, [7:4] zero
);
	import lbps_pkg::*;

	logic [MODE_W-1:0] cur_mode_q, cur_mode_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              led_q, led_d;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              in_accept;
	logic [MODE_W-1:0] in_mode;
	logic [MODE_W-1:0] enter_mode;
	logic              do_enter;
	logic [CNT_W-1:0]  dur;
	logic [STEP_W-1:0] step_inc;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign in_mode       = s_axis_tdata[MODE_W-1:0];
	assign dur           = pattern_dur(cur_mode_q, step_q);
	assign step_inc      = step_q + 3'd1;

	always_comb begin
		cur_mode_d = cur_mode_q;
		step_d     = step_q;
		cnt_d      = cnt_q;
		led_d      = led_q;
		do_enter   = 1'b0;
		enter_mode = in_mode;
		case (s_axis_tuser)
			ACT_TICK: begin
				if (cur_mode_q >= MODE_FIRST_FLASH) begin
					if (cnt_q == '0) begin
						if (dur != '0) begin
							cnt_d = dur;
						end else begin
							step_d = '0;
							led_d  = 1'b0;
						end
					end else begin
						cnt_d = cnt_q - 6'd1;
						if (cnt_q == 6'd1) begin
							step_d = step_inc;
							led_d  = step_inc[0];
						end
					end
				end
			end
			ACT_SET: begin
				do_enter = (in_mode <= MODE_LAST);
			end
			ACT_NEXT: begin
				do_enter   = 1'b1;
				enter_mode = (cur_mode_q == MODE_LAST) ? MODE_OFF : cur_mode_q + 3'd1;
			end
			default: begin
			end
		endcase
		if (do_enter) begin
			cur_mode_d = enter_mode;
			step_d     = '0;
			cnt_d      = '0;
			led_d      = (enter_mode == MODE_ON);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode_q  <= MODE_OFF;
			step_q      <= '0;
			cnt_q       <= '0;
			led_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				cur_mode_q <= cur_mode_d;
				step_q     <= step_d;
				cnt_q      <= cnt_d;
				led_q      <= led_d;
			end
			if (s_axis_tready) begin
				out_valid_q <= s_axis_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q <= {4'b0000, cur_mode_d, led_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_mode_q <= MODE_LAST)
		else $error("mode register out of range");

	a_cnt_flash_only: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> cur_mode_q >= MODE_FIRST_FLASH)
		else $error("countdown running outside a flash mode");

	a_steady_led: assert property (@(posedge clk) disable iff (!arst_n)
		cur_mode_q < MODE_FIRST_FLASH |-> led_q == cur_mode_q[0])
		else $error("LED level disagrees with steady mode");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> m_axis_tvalid && m_axis_tdata[3:1] == cur_mode_q
			&& m_axis_tdata[0] == led_q)
		else $error("result does not match state after accepted item");

endmodule
